/* rtl/running_stats_table_assert.svh */
// Assertion macros used by the checker of the statistics table.
`ifndef RUNNING_STATS_TABLE_ASSERT_SVH
`define RUNNING_STATS_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSTAT_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSTAT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rstat_pkg.sv */
package rstat_pkg;

  localparam int CHANNELS    = 16;
  localparam int CH_BITS     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS = 24;

  localparam logic [23:0] SAMPLE_MASK = 24'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [15:0] COUNT_FULL  = 16'hFFFF;
  localparam logic [47:0] MASK48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] MASK40      = 40'hFF_FFFF_FFFF;

  // operation codes; any other code only reads
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // step counts of the iterative unit
  localparam logic [6:0] Q_STEPS   = 7'd41;
  localparam logic [6:0] VAR_STEPS = 7'd64;
  localparam logic [6:0] MUL_STEPS = 7'd40;

  typedef enum logic {
    UNIT_MUL,
    UNIT_DIV
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
    logic [6:0] steps;
  } unit_ctl_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  channel;
    logic [23:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sample_count;
    logic [39:0] mean_value;
    logic [47:0] variance_value;
    logic [23:0] min_sample;
    logic [23:0] max_sample;
    logic [39:0] total_value;
    logic        sample_dropped;
  } out_item_t;

endpackage

/* rtl/running_stats_table.sv */
// Per-channel running statistics table (Welford update in fixed point).
// Input channel in_valid/in_stall/in_data carries one transaction: an
// operation (add sample, clear, read; unknown codes read), a channel and a
// sample. Each transaction returns exactly one result on out_valid/out_stall/
// out_data: count, Q.16 mean, Q.4 sample variance, min, max, rounded total
// and a flag for an add dropped at full count.
// One item is handled at a time; in_stall is high from the cycle after
// acceptance until the result has moved into the output register.
// All multiplies and divides run on one shared bit-serial unit, one bit per
// cycle. An add that is not dropped runs a 41-step divide for the mean step
// and a 40-step multiply for M2; every transaction then runs a 64-step divide
// for the variance when the count is two or more, and a 40-step multiply for
// the total. No new transaction is taken until the last result has moved
// into the output register. The output register parts the sides: the next
// item is accepted while a result waits under out_stall; a finished result
// then waits for the slot.
// Reset clears every channel at once through per-channel valid bits.
module running_stats_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rstat_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rstat_pkg::out_item_t out_data
);

  localparam int CB = rstat_pkg::CH_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DIV_Q,
    S_MUL_M2,
    S_WRITE,
    S_VAR,
    S_DIV_V,
    S_TOT,
    S_MUL_T,
    S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] count_store  [rstat_pkg::CHANNELS];
  logic [39:0] mean_store   [rstat_pkg::CHANNELS];
  logic [63:0] spread_store [rstat_pkg::CHANNELS];
  logic [23:0] min_store    [rstat_pkg::CHANNELS];
  logic [23:0] max_store    [rstat_pkg::CHANNELS];
  logic [rstat_pkg::CHANNELS-1:0] valid_r;

  logic [1:0]  op_r;
  logic [CB-1:0] idx_r;
  logic [23:0] sample_r;

  logic [15:0] n_r;
  logic [39:0] mean_r;
  logic [63:0] m2_r;
  logic [23:0] min_r, max_r;
  logic        up_r;
  logic [39:0] mag_r;
  logic        dropped_r;
  logic [47:0] var_r;
  logic [39:0] tot_r;

  logic                 out_valid_r;
  rstat_pkg::out_item_t out_data_r;

  rstat_pkg::unit_ctl_t u_ctl;
  logic [63:0]          u_opa;
  logic [39:0]          u_opb;
  logic                 u_done;
  logic [63:0]          u_acc;
  logic [40:0]          u_hi;

  rstat_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (u_ctl),
    .opa   (u_opa),
    .opb   (u_opb),
    .done  (u_done),
    .acc_o (u_acc),
    .hi_o  (u_hi)
  );

  // entry read, empty values where the channel was never written or cleared
  logic [CB-1:0] in_idx;
  logic        rd_ok;
  logic [15:0] ent_n;
  logic [39:0] ent_mean;
  logic [63:0] ent_m2;
  logic [23:0] ent_min, ent_max;
  logic        add_ok;
  logic [15:0] n_inc;
  logic [39:0] xq;
  logic        up_w;
  logic [39:0] mag_w;
  logic [40:0] dvd_q;
  logic [39:0] q_w;
  logic [79:0] prod_w;
  logic [79:0] m2_rnd;
  logic [64:0] m2_sum;
  logic [15:0] d_w;
  logic        var_up;
  logic [64:0] var_sum;
  logic [79:0] tot_rnd;
  logic        accept;
  logic        out_free;

  always_comb begin
    in_idx   = CB'(in_data.channel);
    rd_ok    = valid_r[idx_r] && (op_r != rstat_pkg::OP_CLEAR);
    ent_n    = rd_ok ? n_r    : 16'd0;
    ent_mean = rd_ok ? mean_r : 40'd0;
    ent_m2   = rd_ok ? m2_r   : 64'd0;
    ent_min  = rd_ok ? min_r  : rstat_pkg::SAMPLE_MASK;
    ent_max  = rd_ok ? max_r  : 24'd0;
    add_ok   = (op_r == rstat_pkg::OP_ADD) && (ent_n != rstat_pkg::COUNT_FULL);
    n_inc    = ent_n + 16'd1;
    xq       = {sample_r, 16'd0};
    up_w     = xq >= ent_mean;
    mag_w    = up_w ? (xq - ent_mean) : (ent_mean - xq);
    dvd_q    = {1'b0, mag_w} + {25'd0, (n_inc >> 1)};
    q_w      = u_acc[39:0];
    prod_w   = {u_hi[39:0], u_acc[39:0]};
    m2_rnd   = prod_w + (80'd1 << 27);
    m2_sum   = {1'b0, m2_r} + {13'd0, m2_rnd[79:28]};
    d_w      = n_r - 16'd1;
    var_up   = {u_hi[15:0], 1'b0} >= {1'b0, d_w};
    var_sum  = {1'b0, u_acc} + {64'd0, var_up};
    tot_rnd  = prod_w + (80'd1 << 15);
    accept   = in_valid && (state_r == S_IDLE);
    out_free = !out_valid_r || !out_stall;
  end

  // drive the shared unit
  always_comb begin
    u_ctl.start = 1'b0;
    u_ctl.mode  = rstat_pkg::UNIT_MUL;
    u_ctl.steps = rstat_pkg::MUL_STEPS;
    u_opa       = '0;
    u_opb       = '0;
    case (state_r)
      S_FETCH: begin
        if (add_ok) begin
          u_ctl.start = 1'b1;
          u_ctl.mode  = rstat_pkg::UNIT_DIV;
          u_ctl.steps = rstat_pkg::Q_STEPS;
          u_opa       = {dvd_q, 23'd0};
          u_opb       = {24'd0, n_inc};
        end
      end
      S_DIV_Q: begin
        if (u_done) begin
          u_ctl.start = 1'b1;
          u_opa       = {24'd0, mag_r};
          u_opb       = mag_r - q_w;
        end
      end
      S_VAR: begin
        if (n_r >= 16'd2) begin
          u_ctl.start = 1'b1;
          u_ctl.mode  = rstat_pkg::UNIT_DIV;
          u_ctl.steps = rstat_pkg::VAR_STEPS;
          u_opa       = m2_r;
          u_opb       = {24'd0, d_w};
        end
      end
      S_TOT: begin
        u_ctl.start = 1'b1;
        u_opa       = {24'd0, mean_r};
        u_opb       = {24'd0, n_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      count_store[idx_r]  <= n_r;
      mean_store[idx_r]   <= mean_r;
      spread_store[idx_r] <= m2_r;
      min_store[idx_r]    <= min_r;
      max_store[idx_r]    <= max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            // a channel beyond the table is handled as a read and writes nothing
            if (32'(in_data.channel) < 32'(rstat_pkg::CHANNELS)) begin
              op_r <= in_data.operation;
            end else begin
              op_r <= rstat_pkg::OP_READ;
            end
            idx_r    <= in_idx;
            sample_r <= in_data.sample & rstat_pkg::SAMPLE_MASK;
            n_r      <= count_store[in_idx];
            mean_r   <= mean_store[in_idx];
            m2_r     <= spread_store[in_idx];
            min_r    <= min_store[in_idx];
            max_r    <= max_store[in_idx];
            state_r  <= S_FETCH;
          end
        end
        S_FETCH: begin
          dropped_r <= (op_r == rstat_pkg::OP_ADD) && !add_ok;
          n_r       <= add_ok ? n_inc : ent_n;
          mean_r    <= ent_mean;
          m2_r      <= ent_m2;
          min_r     <= (add_ok && (sample_r < ent_min)) ? sample_r : ent_min;
          max_r     <= (add_ok && (sample_r > ent_max)) ? sample_r : ent_max;
          up_r      <= up_w;
          mag_r     <= mag_w;
          state_r   <= add_ok ? S_DIV_Q : S_VAR;
          if (op_r == rstat_pkg::OP_CLEAR) begin
            valid_r[idx_r] <= 1'b0;
          end
        end
        S_DIV_Q: begin
          if (u_done) begin
            // step the mean toward the sample by the rounded quotient
            mean_r  <= up_r ? (mean_r + q_w) : (mean_r - q_w);
            state_r <= S_MUL_M2;
          end
        end
        S_MUL_M2: begin
          if (u_done) begin
            m2_r    <= m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid_r[idx_r] <= 1'b1;
          state_r        <= S_VAR;
        end
        S_VAR: begin
          var_r <= 48'd0;
          if (n_r >= 16'd2) begin
            state_r <= S_DIV_V;
          end else begin
            state_r <= S_TOT;
          end
        end
        S_DIV_V: begin
          if (u_done) begin
            // round halves up, then clamp to the field
            if (var_sum > {17'd0, rstat_pkg::MASK48}) begin
              var_r <= rstat_pkg::MASK48;
            end else begin
              var_r <= var_sum[47:0];
            end
            state_r <= S_TOT;
          end
        end
        S_TOT: begin
          state_r <= S_MUL_T;
        end
        S_MUL_T: begin
          if (u_done) begin
            if (tot_rnd[79:16] > {24'd0, rstat_pkg::MASK40}) begin
              tot_r <= rstat_pkg::MASK40;
            end else begin
              tot_r <= tot_rnd[55:16];
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r.sample_count    <= n_r;
            out_data_r.mean_value      <= mean_r;
            out_data_r.variance_value  <= var_r;
            out_data_r.min_sample      <= min_r;
            out_data_r.max_sample      <= max_r;
            out_data_r.total_value     <= tot_r;
            out_data_r.sample_dropped  <= dropped_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/rstat_iter_unit.sv */
// Bit-serial multiply / restoring divide unit.
// Divide: opa is the dividend, MSB first from bit 63; opb[15:0] is the divisor.
//   After N steps acc_o[N-1:0] is the quotient, hi_o[15:0] the remainder.
// Multiply: opa[39:0] is the multiplier, opb the multiplicand.
//   After 40 steps {hi_o[39:0], acc_o[39:0]} is the product.
module rstat_iter_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rstat_pkg::unit_ctl_t ctl,
  input  logic [63:0]          opa,
  input  logic [39:0]          opb,
  output logic                 done,
  output logic [63:0]          acc_o,
  output logic [40:0]          hi_o
);

  logic                    busy_r;
  logic                    done_r;
  logic [6:0]              cnt_r;
  rstat_pkg::unit_mode_t   mode_r;
  logic [63:0]             acc_r, acc_nxt;
  logic [40:0]             hi_r, hi_nxt;
  logic [39:0]             b_r;

  logic [16:0] rem_sh;
  logic [16:0] diff;
  logic        ge;
  logic [40:0] sum;

  always_comb begin
    rem_sh  = {hi_r[15:0], acc_r[63]};
    diff    = rem_sh - {1'b0, b_r[15:0]};
    ge      = rem_sh >= {1'b0, b_r[15:0]};
    sum     = hi_r + {1'b0, (acc_r[0] ? b_r : 40'd0)};
    acc_nxt = acc_r;
    hi_nxt  = hi_r;
    if (mode_r == rstat_pkg::UNIT_DIV) begin
      hi_nxt  = {25'd0, (ge ? diff[15:0] : rem_sh[15:0])};
      acc_nxt = {acc_r[62:0], ge};
    end else begin
      // add then shift the double-width product right
      hi_nxt  = {1'b0, sum[40:1]};
      acc_nxt = {acc_r[63:40], sum[0], acc_r[39:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r  <= opa;
      hi_r   <= '0;
      b_r    <= opb;
      mode_r <= ctl.mode;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      hi_r  <= hi_nxt;
    end
  end

  assign done  = done_r;
  assign acc_o = acc_r;
  assign hi_o  = hi_r;

endmodule

/* rtl/rstat_checker.sv */
`include "running_stats_table_assert.svh"

module rstat_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rstat_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rstat_pkg::out_item_t out_data
);

  logic in_acc;
  logic empty_ok;

  assign in_acc   = in_valid && !in_stall;
  assign empty_ok = (out_data.min_sample == rstat_pkg::SAMPLE_MASK) &&
                    (out_data.max_sample == 24'd0) &&
                    (out_data.mean_value == 40'd0) &&
                    (out_data.total_value == 40'd0) &&
                    (out_data.variance_value == 48'd0);

  `RSTAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `RSTAT_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "second transaction taken while busy")
  `RSTAT_ASSERT_NOW(a_empty_reads, out_valid && (out_data.sample_count == 16'd0), empty_ok, "empty channel result not at reset values")
  `RSTAT_ASSERT_NOW(a_drop_at_full, out_valid && out_data.sample_dropped, out_data.sample_count == rstat_pkg::COUNT_FULL, "drop flagged below full count")
  `RSTAT_ASSERT_NOW(a_var_small_count, out_valid && (out_data.sample_count < 16'd2), out_data.variance_value == 48'd0, "variance set below two samples")

endmodule

bind running_stats_table rstat_checker u_rstat_checker (.*);

/* tb/testbench.sv */
module testbench;

  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned HOLDOFF_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES   = 400;
  localparam int unsigned REPORT_MAX     = 10;
  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam int unsigned SPREAD_ADDS    = 40;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [23:0] SAMPLE_TOP     = 24'hFF_FFFF;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  rstat_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rstat_pkg::out_item_t out_data;

  running_stats_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Per-channel statistics as the block should hold them.
  logic [15:0] count_tbl [rstat_pkg::CHANNELS];
  logic [39:0] mean_tbl  [rstat_pkg::CHANNELS];
  logic [63:0] m2_tbl    [rstat_pkg::CHANNELS];
  logic [23:0] min_tbl   [rstat_pkg::CHANNELS];
  logic [23:0] max_tbl   [rstat_pkg::CHANNELS];

  rstat_pkg::out_item_t pending_stats [$];
  int unsigned mismatch_count = 0;

  bit          pacing_on    = 1'b0;
  bit          stall_on     = 1'b0;
  int unsigned burst_left   = 1;
  int          holdoff_req  = 0;
  int          holdoff_seen = 0;
  int unsigned hold_left    = 0;
  logic [7:0]  pattern_age  = 8'd0;
  logic [15:0] stall_pattern = 16'h3C5A;

  function automatic void clear_channel(int c);
    count_tbl[c] = '0;
    mean_tbl[c]  = '0;
    m2_tbl[c]    = '0;
    min_tbl[c]   = rstat_pkg::SAMPLE_MASK;
    max_tbl[c]   = '0;
  endfunction

  // Apply one transaction to the channel table and return what the block must report.
  function automatic rstat_pkg::out_item_t stats_after_item(rstat_pkg::in_item_t it);
    logic [23:0]          x;
    logic [63:0]          n, xq, m, mag, q, prod, s, d, quot, rem;
    logic [127:0]         wide;
    logic                 up;
    int                   c;
    rstat_pkg::out_item_t r;
    x = it.sample & rstat_pkg::SAMPLE_MASK;
    c = int'(it.channel);
    r = '0;
    r.min_sample = rstat_pkg::SAMPLE_MASK;
    if (c >= rstat_pkg::CHANNELS) return r;
    if (it.operation == rstat_pkg::OP_ADD) begin
      if (count_tbl[c] >= rstat_pkg::COUNT_FULL) begin
        r.sample_dropped = 1'b1;
      end else begin
        count_tbl[c] = count_tbl[c] + 16'd1;
        n   = 64'(count_tbl[c]);
        xq  = 64'(x) << 16;
        m   = 64'(mean_tbl[c]);
        up  = (xq >= m);
        mag = up ? xq - m : m - xq;
        // mean step rounds half away from zero, so it never overshoots the sample
        q = (mag + n / 2) / n;
        mean_tbl[c] = 40'(up ? m + q : m - q);
        wide = 128'(mag) * 128'(mag - q) + (128'd1 << 27);
        wide = wide >> 28;
        prod = (wide[127:64] != '0) ? '1 : wide[63:0];
        s = m2_tbl[c] + prod;
        m2_tbl[c] = (s < prod) ? '1 : s;
        if (x < min_tbl[c]) min_tbl[c] = x;
        if (x > max_tbl[c]) max_tbl[c] = x;
      end
    end else if (it.operation == rstat_pkg::OP_CLEAR) begin
      clear_channel(c);
    end
    n = 64'(count_tbl[c]);
    r.sample_count = count_tbl[c];
    r.mean_value   = mean_tbl[c];
    r.min_sample   = min_tbl[c];
    r.max_sample   = max_tbl[c];
    if (n >= 2) begin
      d    = n - 1;
      quot = m2_tbl[c] / d;
      rem  = m2_tbl[c] % d;
      if (2 * rem >= d) quot = quot + 1;
      r.variance_value = (quot > 64'(rstat_pkg::MASK48)) ? rstat_pkg::MASK48 : 48'(quot);
    end
    wide = 128'(n) * 128'(mean_tbl[c]) + (128'd1 << 15);
    wide = wide >> 16;
    r.total_value = (wide > 128'(rstat_pkg::MASK40)) ? rstat_pkg::MASK40 : 40'(wide);
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [3:0] ch, logic [23:0] sample);
    rstat_pkg::in_item_t it;
    int unsigned         gap;
    it.operation = op;
    it.channel   = ch;
    it.sample    = sample;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_stats.insert(pending_stats.size(), stats_after_item(it));
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = pacing_on ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drop valid so the last transaction is not taken twice.
  task automatic input_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rstat_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result with no transaction pending: %h", $realtime, out_data);
      end else begin
        want = pending_stats.pop_front();
        check_field("sample_count",   64'(out_data.sample_count),   64'(want.sample_count));
        check_field("mean_value",     64'(out_data.mean_value),     64'(want.mean_value));
        check_field("variance_value", 64'(out_data.variance_value), 64'(want.variance_value));
        check_field("min_sample",     64'(out_data.min_sample),     64'(want.min_sample));
        check_field("max_sample",     64'(out_data.max_sample),     64'(want.max_sample));
        check_field("total_value",    64'(out_data.total_value),    64'(want.total_value));
        check_field("sample_dropped", 64'(out_data.sample_dropped), 64'(want.sample_dropped));
      end
    end
  end

  // Result side: a rotating stall pattern, reloaded now and then, or a long hold-off.
  always @(negedge clk) begin
    pattern_age <= pattern_age + 8'd1;
    stall_pattern <= (pattern_age == 8'd0) ? 16'($urandom)
                                           : {stall_pattern[0], stall_pattern[15:1]};
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      hold_left    <= HOLDOFF_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_on & stall_pattern[0];
    end
  end

  task automatic test_directed_cases();
    pacing_on = 1'b1;
    stall_on  = 1'b1;
    send_item(rstat_pkg::OP_READ,  4'd0,  24'd0);
    send_item(OP_UNUSED,           4'd15, SAMPLE_TOP);
    send_item(rstat_pkg::OP_ADD,   4'd1,  SAMPLE_TOP);
    send_item(rstat_pkg::OP_ADD,   4'd1,  24'd0);
    send_item(rstat_pkg::OP_ADD,   4'd1,  SAMPLE_TOP);
    send_item(rstat_pkg::OP_ADD,   4'd2,  24'd0);
    send_item(rstat_pkg::OP_READ,  4'd2,  24'd0);
    send_item(rstat_pkg::OP_ADD,   4'd2,  24'd1);
    send_item(rstat_pkg::OP_ADD,   4'd2,  24'd1);
    send_item(rstat_pkg::OP_ADD,   4'd15, 24'hAA_AAAA);
    send_item(rstat_pkg::OP_ADD,   4'd15, 24'h55_5555);
    send_item(OP_UNUSED,           4'd15, 24'd0);
    send_item(rstat_pkg::OP_CLEAR, 4'd1,  SAMPLE_TOP);
    send_item(rstat_pkg::OP_READ,  4'd1,  24'd0);
    send_item(rstat_pkg::OP_ADD,   4'd1,  24'h80_0000);
    send_item(rstat_pkg::OP_CLEAR, 4'd7,  24'd0);
    send_item(rstat_pkg::OP_ADD,   4'd0,  24'd3);
    send_item(rstat_pkg::OP_ADD,   4'd0,  24'd4);
    send_item(rstat_pkg::OP_ADD,   4'd0,  24'd4);
    send_item(rstat_pkg::OP_READ,  4'd0,  SAMPLE_TOP);
    send_item(rstat_pkg::OP_CLEAR, 4'd15, 24'd0);
    input_idle();
  endtask

  task automatic test_random_traffic();
    logic [23:0] base [rstat_pkg::CHANNELS];
    logic [23:0] sample;
    logic [3:0]  ch;
    int unsigned pick;
    for (int c = 0; c < rstat_pkg::CHANNELS; c++) base[c] = 24'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 175 == 0) begin
        pacing_on = ($urandom_range(0, 3) != 0);
        stall_on  = ($urandom_range(0, 3) != 0);
      end
      ch = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: sample = base[ch] + 24'($urandom_range(0, 64)) - 24'd32;
        4:          sample = 24'($urandom_range(0, 255));
        5:          sample = SAMPLE_TOP;
        6:          sample = 24'd0;
        7:          sample = 24'd1 << $urandom_range(0, 23);
        default:    sample = 24'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70)      send_item(rstat_pkg::OP_ADD, ch, sample);
      else if (pick < 84) send_item(rstat_pkg::OP_READ, ch, sample);
      else if (pick < 93) send_item(OP_UNUSED, ch, sample);
      else                send_item(rstat_pkg::OP_CLEAR, ch, sample);
    end
    input_idle();
  endtask

  // Hold the result side off long enough that the block fills and stalls its input.
  task automatic test_output_holdoff();
    pacing_on = 1'b0;
    stall_on  = 1'b0;
    holdoff_req++;
    for (int i = 0; i < 8; i++)
      send_item((i % 3 == 2) ? rstat_pkg::OP_READ : rstat_pkg::OP_ADD,
                4'($urandom_range(3, 5)), 24'($urandom));
    input_idle();
  endtask

  // Alternate extreme samples on one channel so M2 and the variance grow large.
  task automatic test_extreme_spread();
    logic [3:0] ch;
    pacing_on = 1'b0;
    stall_on  = 1'b0;
    ch = 4'd6;
    send_item(rstat_pkg::OP_CLEAR, ch, 24'd0);
    for (int i = 0; i < SPREAD_ADDS; i++)
      send_item(rstat_pkg::OP_ADD, ch, (i % 2 == 1) ? SAMPLE_TOP - 24'($urandom_range(0, 255))
                                                    : 24'($urandom_range(0, 255)));
    stall_on = 1'b1;
    send_item(rstat_pkg::OP_ADD,   ch, SAMPLE_TOP);
    send_item(rstat_pkg::OP_ADD,   ch, 24'd0);
    send_item(rstat_pkg::OP_READ,  ch, 24'd0);
    send_item(OP_UNUSED,           ch, 24'd0);
    send_item(rstat_pkg::OP_CLEAR, ch, 24'd0);
    send_item(rstat_pkg::OP_ADD,   ch, 24'd9);
    input_idle();
  endtask

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int c = 0; c < rstat_pkg::CHANNELS; c++) clear_channel(c);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_output_holdoff();
    test_extreme_spread();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_stats.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
